// ===== hdl/aqi_pkg.sv =====
package aqi_pkg;

    // pollutant codes carried on the input tuser
    localparam logic [1:0] POLL_PM25 = 2'd0;
    localparam logic [1:0] POLL_PM10 = 2'd1;

    localparam int SEG_COUNT = 7;
    localparam int SEG_W     = $clog2(SEG_COUNT);

    // reciprocal scale: every product span * (c - c_low) stays below this
    localparam int          RECIP_SHIFT = 23;
    localparam int unsigned RECIP_ONE   = 32'd1 << RECIP_SHIFT;

    localparam int CONC_W  = 16;
    localparam int INDEX_W = 13;
    localparam int ILOW_W  = 9;
    localparam int SPAN_W  = 7;
    localparam int DEN_W   = 11;
    localparam int RECIP_W = 17;
    localparam int BRK_W   = 13;
    localparam int PROD_W  = SPAN_W + CONC_W;
    localparam int QUOT_W  = RECIP_W;
    localparam int REM_W   = DEN_W + 1;

    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    // one breakpoint segment, concentrations in tenths
    typedef struct packed {
        logic [BRK_W-1:0]   c_top;
        logic [BRK_W-1:0]   c_low;
        logic [ILOW_W-1:0]  i_low;
        logic [SPAN_W-1:0]  span;
        logic [DEN_W-1:0]   den;
        logic [RECIP_W-1:0] recip;
    } seg_t;

    localparam seg_t PM25_SEGS [SEG_COUNT] = '{
        '{13'd120,  13'd0,    9'd0,   7'd50,  11'd120,  RECIP_W'(RECIP_ONE / 120)},
        '{13'd354,  13'd121,  9'd51,  7'd49,  11'd233,  RECIP_W'(RECIP_ONE / 233)},
        '{13'd554,  13'd355,  9'd101, 7'd49,  11'd199,  RECIP_W'(RECIP_ONE / 199)},
        '{13'd1504, 13'd555,  9'd151, 7'd49,  11'd949,  RECIP_W'(RECIP_ONE / 949)},
        '{13'd2504, 13'd1505, 9'd201, 7'd99,  11'd999,  RECIP_W'(RECIP_ONE / 999)},
        '{13'd3504, 13'd2505, 9'd301, 7'd99,  11'd999,  RECIP_W'(RECIP_ONE / 999)},
        '{13'd5004, 13'd3505, 9'd401, 7'd99,  11'd1499, RECIP_W'(RECIP_ONE / 1499)}
    };

    localparam seg_t PM10_SEGS [SEG_COUNT] = '{
        '{13'd540,  13'd0,    9'd0,   7'd50,  11'd540,  RECIP_W'(RECIP_ONE / 540)},
        '{13'd1540, 13'd550,  9'd51,  7'd49,  11'd990,  RECIP_W'(RECIP_ONE / 990)},
        '{13'd2540, 13'd1550, 9'd101, 7'd49,  11'd990,  RECIP_W'(RECIP_ONE / 990)},
        '{13'd3540, 13'd2550, 9'd151, 7'd49,  11'd990,  RECIP_W'(RECIP_ONE / 990)},
        '{13'd4240, 13'd3550, 9'd201, 7'd99,  11'd690,  RECIP_W'(RECIP_ONE / 690)},
        '{13'd5040, 13'd4250, 9'd301, 7'd99,  11'd790,  RECIP_W'(RECIP_ONE / 790)},
        '{13'd6040, 13'd5050, 9'd401, 7'd99,  11'd990,  RECIP_W'(RECIP_ONE / 990)}
    };

    // classified item handed from the front to the back
    typedef struct packed {
        logic               status;
        logic               below;
        logic [CONC_W-1:0]  diff;
        logic [SPAN_W-1:0]  span;
        logic [DEN_W-1:0]   den;
        logic [RECIP_W-1:0] recip;
        logic [ILOW_W-1:0]  i_low;
    } work_t;

endpackage

// ===== hdl/air_quality_index_piecewise_unit.sv =====
// particulate air quality index (pm2.5 / pm10), piecewise linear on fixed breakpoints
//
// input channel s_*: s_tdata carries the concentration in tenths of ug/m3,
// s_tuser the pollutant code (pm2.5 or pm10, other codes flagged as errors)
// result channel m_*: m_tdata carries the index, m_tuser the error status;
// one result item per input item, in order
// path: front input register, queue, then the back pipeline into the output register
// throughput: one item per cycle when nothing stalls; the back end is a four-stage
// pipeline (span product, reciprocal multiply, remainder, correction) fed by a queue
// reset: aresetn low on a clock edge empties every stage and the queue; the block
// holds no other state
// stall: while m_tready is low and the output register is full, the back pipeline
// and output register hold; the front keeps filling the queue and drops s_tready
// only when the queue and the front register are both full
module air_quality_index_piecewise_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] concentration
    input  logic [1:0]  s_tuser,    // [1:0] pollutant
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [12:0] index_value, [15:13] zero
    output logic [0:0]  m_tuser     // [0] status
);

    logic                               push_valid;
    logic                               push_ready;
    aqi_pkg::work_t                     push_item;
    logic                               pop_valid;
    logic                               pop_ready;
    aqi_pkg::work_t                     pop_item;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_fill;

    // front: input register with segment search and offset
    aqi_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // short queue decoupling the front from the arithmetic pipeline
    aqi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .fill       (queue_fill)
    );

    // back: interpolation by reciprocal multiply and one-step correction
    aqi_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // an error result always carries a zero index
    a_error_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0)
        else $error("error item with non-zero index");

    // the largest index reachable is pm10 at full scale
    a_index_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= 16'd6449)
        else $error("index above reachable range");

    // queue never overfills
    a_queue_fill : assert property (@(posedge aclk) disable iff (!aresetn)
        queue_fill <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    // a full front register with a full queue must hold off the input
    a_backpressure : assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid && !push_ready |-> !s_tready)
        else $error("input accepted while front is blocked");

endmodule

// ===== hdl/aqi_front.sv =====
module aqi_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,
    input  logic [1:0]                  s_tuser,
    output logic                        push_valid,
    input  logic                        push_ready,
    output aqi_pkg::work_t              push_item
);

    logic                               fr_valid_reg;
    logic                               fr_valid_next;
    aqi_pkg::work_t                     fr_item_reg;
    aqi_pkg::work_t                     cls_item;
    aqi_pkg::seg_t                      seg;
    logic [aqi_pkg::SEG_W-1:0]          seg_sel;
    logic [aqi_pkg::CONC_W-1:0]         conc;
    logic [aqi_pkg::CONC_W-1:0]         c_low_ext;
    logic                               accept;
    logic                               valid_kind;

    assign conc     = s_tdata[aqi_pkg::CONC_W-1:0];
    assign accept   = s_tvalid && s_tready;
    assign s_tready = !fr_valid_reg || push_ready;

    // segment search: first segment whose top covers the concentration
    always_comb begin
        seg_sel    = aqi_pkg::SEG_W'(aqi_pkg::SEG_COUNT - 1);
        valid_kind = (s_tuser == aqi_pkg::POLL_PM25) || (s_tuser == aqi_pkg::POLL_PM10);
        for (int i = aqi_pkg::SEG_COUNT - 1; i >= 0; i--) begin
            if (s_tuser == aqi_pkg::POLL_PM10) begin
                if (conc <= aqi_pkg::CONC_W'(aqi_pkg::PM10_SEGS[i].c_top)) begin
                    seg_sel = aqi_pkg::SEG_W'(i);
                end
            end else begin
                if (conc <= aqi_pkg::CONC_W'(aqi_pkg::PM25_SEGS[i].c_top)) begin
                    seg_sel = aqi_pkg::SEG_W'(i);
                end
            end
        end
        seg = (s_tuser == aqi_pkg::POLL_PM10) ? aqi_pkg::PM10_SEGS[seg_sel]
                                              : aqi_pkg::PM25_SEGS[seg_sel];
    end

    always_comb begin
        c_low_ext = aqi_pkg::CONC_W'(seg.c_low);
        cls_item  = '0;
        if (!valid_kind) begin
            cls_item.status = 1'b1;
        end else begin
            // a concentration in the gap below a segment lands under its i_low;
            // diff is then the distance down to c_low
            cls_item.below = conc < c_low_ext;
            cls_item.diff  = (conc < c_low_ext) ? c_low_ext - conc : conc - c_low_ext;
            cls_item.span  = seg.span;
            cls_item.den   = seg.den;
            cls_item.recip = seg.recip;
            cls_item.i_low = seg.i_low;
        end
    end

    always_comb begin
        fr_valid_next = fr_valid_reg;
        if (accept) begin
            fr_valid_next = 1'b1;
        end else if (push_ready) begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fr_item_reg <= cls_item;
        end
    end

    assign push_valid = fr_valid_reg;
    assign push_item  = fr_item_reg;

endmodule

// ===== hdl/aqi_queue.sv =====
module aqi_queue #(
    parameter int DEPTH = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push_valid,
    output logic                        push_ready,
    input  aqi_pkg::work_t              push_item,
    output logic                        pop_valid,
    input  logic                        pop_ready,
    output aqi_pkg::work_t              pop_item,
    output logic [$clog2(DEPTH+1)-1:0]  fill
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aqi_pkg::work_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg < CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign fill       = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/aqi_back.sv =====
module aqi_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  aqi_pkg::work_t              pop_item,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,
    output logic [0:0]                  m_tuser
);

    typedef struct packed {
        logic                           status;
        logic                           below;
        logic [aqi_pkg::DEN_W-1:0]      den;
        logic [aqi_pkg::ILOW_W-1:0]     i_low;
    } side_t;

    logic                               adv;

    // stage 1: product of span and offset
    logic                               s1_valid_reg;
    side_t                              s1_side_reg;
    logic [aqi_pkg::PROD_W-1:0]         s1_prod_reg;
    logic [aqi_pkg::RECIP_W-1:0]        s1_recip_reg;

    // stage 2: estimated quotient by reciprocal
    logic                               s2_valid_reg;
    side_t                              s2_side_reg;
    logic [aqi_pkg::PROD_W-1:0]         s2_prod_reg;
    logic [aqi_pkg::QUOT_W-1:0]         s2_quot_reg;
    logic [aqi_pkg::PROD_W+aqi_pkg::RECIP_W-1:0] s2_wide;

    // stage 3: remainder of the estimate
    logic                               s3_valid_reg;
    side_t                              s3_side_reg;
    logic [aqi_pkg::QUOT_W-1:0]         s3_quot_reg;
    logic [aqi_pkg::REM_W-1:0]          s3_rem_reg;
    logic [aqi_pkg::QUOT_W+aqi_pkg::DEN_W-1:0] s3_back;
    logic [aqi_pkg::QUOT_W+aqi_pkg::DEN_W-1:0] s3_rem_full;

    // stage 4: correction, offset and output register
    logic                               out_valid_reg;
    logic [aqi_pkg::INDEX_W-1:0]        out_index_reg;
    logic                               out_status_reg;
    logic [aqi_pkg::INDEX_W-1:0]        out_index_next;
    logic [aqi_pkg::QUOT_W-1:0]         quot_fix;
    logic [aqi_pkg::REM_W-1:0]          rem_fix;
    logic [aqi_pkg::QUOT_W:0]           ceil_quot;
    logic [aqi_pkg::QUOT_W:0]           index_sum;

    assign adv       = !out_valid_reg || m_tready;
    assign pop_ready = adv;

    assign s2_wide     = (aqi_pkg::PROD_W + aqi_pkg::RECIP_W)'(s1_prod_reg)
                       * (aqi_pkg::PROD_W + aqi_pkg::RECIP_W)'(s1_recip_reg);
    assign s3_back     = (aqi_pkg::QUOT_W + aqi_pkg::DEN_W)'(s2_quot_reg)
                       * (aqi_pkg::QUOT_W + aqi_pkg::DEN_W)'(s2_side_reg.den);
    assign s3_rem_full = (aqi_pkg::QUOT_W + aqi_pkg::DEN_W)'(s2_prod_reg) - s3_back;

    always_comb begin
        quot_fix  = s3_quot_reg
                  + aqi_pkg::QUOT_W'(s3_rem_reg >= aqi_pkg::REM_W'(s3_side_reg.den));
        rem_fix   = (s3_rem_reg >= aqi_pkg::REM_W'(s3_side_reg.den))
                  ? s3_rem_reg - aqi_pkg::REM_W'(s3_side_reg.den) : s3_rem_reg;
        // below c_low the floor steps down by the rounded-up quotient
        ceil_quot = (aqi_pkg::QUOT_W + 1)'(quot_fix)
                  + (aqi_pkg::QUOT_W + 1)'(rem_fix != '0);
        index_sum = (aqi_pkg::QUOT_W + 1)'(s3_side_reg.i_low)
                  + (aqi_pkg::QUOT_W + 1)'(quot_fix);
        if (s3_side_reg.status) begin
            out_index_next = '0;
        end else if (s3_side_reg.below) begin
            out_index_next = ((aqi_pkg::QUOT_W + 1)'(s3_side_reg.i_low) > ceil_quot)
                           ? aqi_pkg::INDEX_W'((aqi_pkg::QUOT_W + 1)'(s3_side_reg.i_low)
                                               - ceil_quot)
                           : '0;
        end else if (index_sum > (aqi_pkg::QUOT_W + 1)'(aqi_pkg::INDEX_MAX)) begin
            out_index_next = aqi_pkg::INDEX_MAX;
        end else begin
            out_index_next = index_sum[aqi_pkg::INDEX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= pop_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_side_reg.status <= pop_item.status;
            s1_side_reg.below  <= pop_item.below;
            s1_side_reg.den    <= pop_item.den;
            s1_side_reg.i_low  <= pop_item.i_low;
            s1_prod_reg        <= aqi_pkg::PROD_W'(pop_item.span) * aqi_pkg::PROD_W'(pop_item.diff);
            s1_recip_reg       <= pop_item.recip;

            s2_side_reg        <= s1_side_reg;
            s2_prod_reg        <= s1_prod_reg;
            s2_quot_reg        <= s2_wide[aqi_pkg::RECIP_SHIFT +: aqi_pkg::QUOT_W];

            s3_side_reg        <= s2_side_reg;
            s3_quot_reg        <= s2_quot_reg;
            s3_rem_reg         <= s3_rem_full[aqi_pkg::REM_W-1:0];

            out_index_reg      <= out_index_next;
            out_status_reg     <= s3_side_reg.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - aqi_pkg::INDEX_W){1'b0}}, out_index_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ===== sim/tb_air_quality_index_piecewise_unit.sv =====
module tb_air_quality_index_piecewise_unit;

    // pollutant codes with no breakpoint table
    localparam logic [1:0] POLL_BAD_A = 2'd2;
    localparam logic [1:0] POLL_BAD_B = 2'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    localparam int IDLE_PCT    = 31;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;

    // one breakpoint segment, concentrations in tenths of ug/m3
    typedef struct packed {
        int c_top;
        int c_low;
        int c_high;
        int i_low;
        int i_high;
    } brk_t;

    localparam brk_t PM25_BRK [7] = '{
        '{120,  0,    120,  0,   50},
        '{354,  121,  354,  51,  100},
        '{554,  355,  554,  101, 150},
        '{1504, 555,  1504, 151, 200},
        '{2504, 1505, 2504, 201, 300},
        '{3504, 2505, 3504, 301, 400},
        '{5004, 3505, 5004, 401, 500}
    };

    localparam brk_t PM10_BRK [7] = '{
        '{540,  0,    540,  0,   50},
        '{1540, 550,  1540, 51,  100},
        '{2540, 1550, 2540, 101, 150},
        '{3540, 2550, 3540, 151, 200},
        '{4240, 3550, 4240, 201, 300},
        '{5040, 4250, 5040, 301, 400},
        '{6040, 5050, 6040, 401, 500}
    };

    typedef struct {
        logic [1:0]  pollutant;
        logic [15:0] conc;
        logic [12:0] index_value;
        logic        status;
    } aqi_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    aqi_result_t aqi_pending [$];
    int          mismatches;
    int          cycle_count;
    bit          src_idle_en;
    bit          sink_idle_en;
    bit          hold_req;

    air_quality_index_piecewise_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // index for one pollutant reading, floor of the exact rational interpolation
    function automatic aqi_result_t aqi_of(logic [1:0] poll, logic [15:0] conc);
        aqi_result_t r;
        brk_t        seg;
        int          k;
        longint      den;
        longint      num;
        longint      q;
        r.pollutant   = poll;
        r.conc        = conc;
        r.index_value = '0;
        r.status      = STATUS_OK;
        if (poll != aqi_pkg::POLL_PM25 && poll != aqi_pkg::POLL_PM10) begin
            r.status = STATUS_BAD;
            return r;
        end
        // above the table the top segment is extended
        k = 6;
        for (int i = 6; i >= 0; i--) begin
            seg = (poll == aqi_pkg::POLL_PM25) ? PM25_BRK[i] : PM10_BRK[i];
            if (longint'(conc) <= longint'(seg.c_top))
                k = i;
        end
        seg = (poll == aqi_pkg::POLL_PM25) ? PM25_BRK[k] : PM10_BRK[k];
        den = longint'(seg.c_high - seg.c_low);
        num = longint'(seg.i_low) * den
            + longint'(seg.i_high - seg.i_low) * (longint'(conc) - longint'(seg.c_low));
        q = num / den;
        if (num % den != 0 && num < 0)
            q = q - 1;
        if (q < 0)
            q = 0;
        if (q > 8191)
            q = 8191;
        r.index_value = q[12:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // offers one item from the falling edge on, returns at the accepting rising edge
    task automatic send_item(input logic [1:0] poll, input logic [15:0] conc);
        @(negedge aclk);
        while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= poll;
        s_tdata  <= conc;
        do
            @(posedge aclk);
        while (!s_tready);
        aqi_pending.push_back(aqi_of(poll, conc));
    endtask

    task automatic src_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [1:0] rand_pollutant();
        int r;
        r = $urandom_range(99);
        if (r < 44)
            return aqi_pkg::POLL_PM25;
        else if (r < 88)
            return aqi_pkg::POLL_PM10;
        else if (r < 94)
            return POLL_BAD_A;
        return POLL_BAD_B;
    endfunction

    // mostly inside the tables, a good share on the segment edges
    function automatic logic [15:0] rand_conc(logic [1:0] poll);
        int   v;
        int   k;
        brk_t seg;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom_range(6100);
            4, 5: begin
                k   = $urandom_range(6);
                seg = (poll == aqi_pkg::POLL_PM10) ? PM10_BRK[k] : PM25_BRK[k];
                v   = seg.c_top + $urandom_range(6) - 3;
                if (v < 0)
                    v = 0;
            end
            6: v = $urandom_range(65535, 6041);
            default: v = $urandom();
        endcase
        return v[15:0];
    endfunction

    // result checker
    always @(posedge aclk) begin
        aqi_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (aqi_pending.size() == 0) begin
                report_mismatch($sformatf("unexpected item tdata=%h tuser=%b",
                                          m_tdata, m_tuser));
            end else begin
                e = aqi_pending.pop_front();
                if (m_tdata[12:0] !== e.index_value)
                    report_mismatch($sformatf("poll=%0d conc=%0d index %0d, want %0d",
                                              e.pollutant, e.conc, m_tdata[12:0],
                                              e.index_value));
                if (m_tdata[15:13] !== 3'b000)
                    report_mismatch($sformatf("poll=%0d conc=%0d pad bits %b",
                                              e.pollutant, e.conc, m_tdata[15:13]));
                if (m_tuser[0] !== e.status)
                    report_mismatch($sformatf("poll=%0d conc=%0d status %b, want %b",
                                              e.pollutant, e.conc, m_tuser[0], e.status));
            end
        end
    end

    // receiver: random stalls plus the requested long hold-off
    initial begin : sink
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_idle_en && $urandom_range(99) < IDLE_PCT) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic test_segment_edges();
        send_item(aqi_pkg::POLL_PM25, 16'd0);
        send_item(aqi_pkg::POLL_PM25, 16'd120);
        send_item(aqi_pkg::POLL_PM25, 16'd121);
        send_item(aqi_pkg::POLL_PM25, 16'd354);
        send_item(aqi_pkg::POLL_PM25, 16'd355);
        send_item(aqi_pkg::POLL_PM25, 16'd5004);
        send_item(aqi_pkg::POLL_PM10, 16'd0);
        send_item(aqi_pkg::POLL_PM10, 16'd540);
        send_item(aqi_pkg::POLL_PM10, 16'd550);
        send_item(aqi_pkg::POLL_PM10, 16'd1540);
        src_quiet();
    endtask

    // pm10 readings between one segment's top and the next one's bottom,
    // including the steep segments where the floor drops two steps
    task automatic test_pm10_gaps();
        send_item(aqi_pkg::POLL_PM10, 16'd541);
        send_item(aqi_pkg::POLL_PM10, 16'd549);
        send_item(aqi_pkg::POLL_PM10, 16'd1545);
        send_item(aqi_pkg::POLL_PM10, 16'd3541);
        send_item(aqi_pkg::POLL_PM10, 16'd4241);
        src_quiet();
    endtask

    // extrapolation past the top segment up to full scale
    task automatic test_above_table();
        send_item(aqi_pkg::POLL_PM25, 16'd5005);
        send_item(aqi_pkg::POLL_PM25, 16'hFFFF);
        send_item(aqi_pkg::POLL_PM10, 16'd6041);
        send_item(aqi_pkg::POLL_PM10, 16'hFFFF);
        src_quiet();
    endtask

    task automatic test_invalid_codes();
        send_item(POLL_BAD_A, 16'h0000);
        send_item(POLL_BAD_B, 16'hFFFF);
        send_item(POLL_BAD_A, 16'hAAAA);
        send_item(POLL_BAD_B, 16'h5555);
        src_quiet();
    endtask

    task automatic test_random_mix(input int n);
        logic [1:0] p;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        repeat (n) begin
            p = rand_pollutant();
            send_item(p, rand_conc(p));
        end
        src_quiet();
    endtask

    // back to back on both sides
    task automatic test_full_rate(input int n);
        logic [1:0] p;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (n) begin
            p = rand_pollutant();
            send_item(p, rand_conc(p));
        end
        src_quiet();
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure(input int n);
        logic [1:0] p;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_req     = 1'b1;
        repeat (n) begin
            p = rand_pollutant();
            send_item(p, rand_conc(p));
        end
        src_quiet();
        sink_idle_en = 1'b1;
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        mismatches   = 0;
        cycle_count  = 0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        hold_req     = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_segment_edges();
        test_pm10_gaps();
        test_above_table();
        test_invalid_codes();
        test_random_mix(300);
        test_backpressure(40);
        test_full_rate(110);
        test_random_mix(200);

        while (aqi_pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
